// ----- design/hbcc_pkg.sv -----
// hbcc_pkg: shared types, register indexes and color thresholds of the hsv tile classifier
// depends on nothing; imported by hbcc_tile_accum and hsv_block_color_classifier_top
package hbcc_pkg;

   // configuration register indexes
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // configuration field width
   localparam int CFG_W = 12;

   // register reset values
   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   // classification thresholds on the tile averages
   localparam logic [7:0] SAT_MIN          = 8'd43;
   localparam logic [7:0] VAL_MIN          = 8'd46;
   localparam logic [7:0] HUE_RED_LOW_MAX  = 8'd14;
   localparam logic [7:0] HUE_YELLOW_MAX   = 8'd45;
   localparam logic [7:0] HUE_GREEN_MAX    = 8'd77;
   localparam logic [7:0] HUE_CYAN_MAX     = 8'd109;
   localparam logic [7:0] HUE_BLUE_MAX     = 8'd134;
   localparam logic [7:0] HUE_RED_HIGH_MIN = 8'd159;
   localparam logic [7:0] HUE_MAGENTA_MAX  = 8'd160;
   localparam logic [7:0] HUE_LIMIT        = 8'd180;
   localparam logic [7:0] BLACK_VAL_MAX    = 8'd149;
   localparam logic [7:0] WHITE_SAT_MAX    = 8'd40;

   // fill color for tiles that do not keep their average
   localparam logic [7:0] PLAIN_HUE = 8'd0;
   localparam logic [7:0] PLAIN_SAT = 8'd0;
   localparam logic [7:0] PLAIN_VAL = 8'd255;

   typedef enum logic [3:0] {
      CLASS_RED     = 4'd0,
      CLASS_YELLOW  = 4'd1,
      CLASS_GREEN   = 4'd2,
      CLASS_CYAN    = 4'd3,
      CLASS_BLUE    = 4'd4,
      CLASS_MAGENTA = 4'd5,
      CLASS_BLACK   = 4'd6,
      CLASS_WHITE   = 4'd7,
      CLASS_UNKNOWN = 4'd8
   } color_class_type;

   // position flags of one pixel within its tile
   typedef struct packed {
      logic first;
      logic last;
   } tile_ctl_type;

   // finished tile: position and averages
   typedef struct packed {
      logic [7:0] tile_col;
      logic [7:0] tile_row;
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } tile_avg_type;

   // priority classification of the averages
   function automatic color_class_type classify(input logic [7:0] h, input logic [7:0] s,
                                                input logic [7:0] v);
      logic sv;
      color_class_type cls;
      sv = (s >= SAT_MIN) && (v >= VAL_MIN);
      priority if (sv && (h <= HUE_RED_LOW_MAX || (h >= HUE_RED_HIGH_MIN && h <= HUE_LIMIT)))
         cls = CLASS_RED;
      else if (sv && h <= HUE_YELLOW_MAX)
         cls = CLASS_YELLOW;
      else if (sv && h <= HUE_GREEN_MAX)
         cls = CLASS_GREEN;
      else if (sv && h <= HUE_CYAN_MAX)
         cls = CLASS_CYAN;
      else if (sv && h <= HUE_BLUE_MAX)
         cls = CLASS_BLUE;
      else if (sv && h <= HUE_MAGENTA_MAX)
         cls = CLASS_MAGENTA;
      else if (h <= HUE_LIMIT && v <= BLACK_VAL_MAX)
         cls = CLASS_BLACK;
      else if (h <= HUE_LIMIT && s <= WHITE_SAT_MAX && v > BLACK_VAL_MAX)
         cls = CLASS_WHITE;
      else
         cls = CLASS_UNKNOWN;
      return cls;
   endfunction

   // classes that paint the tile with its own average
   function automatic logic keeps_average(input color_class_type cls);
      return (cls == CLASS_RED) || (cls == CLASS_YELLOW) || (cls == CLASS_MAGENTA) ||
             (cls == CLASS_BLACK);
   endfunction

endpackage

// ----- design/hsv_block_color_classifier_top.sv -----
// hsv_block_color_classifier_top: raster position, configuration registers, classification
// depends on hbcc_pkg and hbcc_tile_accum
//
// Takes one HSV pixel per clock in raster order, unless stalled, and sums each
// square tile of 2^BLOCK_LOG2 pixels a side in a memory holding one word per
// tile column. A pixel is taken every cycle unless stalled: the memory has one
// read and one write port, the read for a pixel happens when it is taken, its
// write-back at stage 1, and a write-back to the same column is forwarded to
// the pixel behind it. The request is stalled only while a finished tile cannot
// move on because the result side stalls. A tile's result leaves through the
// sum write-back, average register and result register. Pixels to the right of
// or below the last whole tile only advance the position. Width and height are
// written over the csr_ port (0 acts as 1, sizes above MAX_WIDTH or MAX_HEIGHT
// saturate); the user changes them only while the block is idle (not enforced).
module hsv_block_color_classifier_top
   import hbcc_pkg::*;
#(
   parameter int BLOCK_LOG2 = 3,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // pixel requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_hue,
   input  logic [7:0]  req_sat,
   input  logic [7:0]  req_val,
   input  logic        req_frame_start,
   // tile results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tile_col,
   output logic [7:0]  rsp_tile_row,
   output logic [3:0]  rsp_color_class,
   output logic [7:0]  rsp_fill_hue,
   output logic [7:0]  rsp_fill_sat,
   output logic [7:0]  rsp_fill_val,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TILE_COLS = MAX_WIDTH >> BLOCK_LOG2;
   localparam int TCW       = $clog2(TILE_COLS);
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int RW        = $clog2(MAX_HEIGHT);
   localparam int SW        = $clog2(MAX_WIDTH + 1);
   localparam int SH        = $clog2(MAX_HEIGHT + 1);
   localparam int CMP_W     = ((SW > SH) ? SW : SH) > CFG_W ? ((SW > SH) ? SW : SH) : CFG_W;
   localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] MAX_H_CMP = CMP_W'(MAX_HEIGHT);
   localparam logic [SW-1:0] W_LOW_MASK = SW'((1 << BLOCK_LOG2) - 1);
   localparam logic [SH-1:0] H_LOW_MASK = SH'((1 << BLOCK_LOG2) - 1);
   localparam logic [BLOCK_LOG2-1:0] IN_TILE_LAST = '1;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   logic             rsp_valid_ff, rsp_valid_in;
   tile_avg_type     rsp_ff;
   color_class_type  rsp_class_ff;

   logic             cfg_write, req_fire, rsp_load;
   logic [CMP_W-1:0] width_cmp, height_cmp;
   logic [SW-1:0]    img_w, whole_w, col_ext, col_next;
   logic [SH-1:0]    img_h, whole_h, row_ext, row_next;
   logic [CW-1:0]    col;
   logic [RW-1:0]    row;
   logic             in_tile;
   tile_ctl_type     op_ctl;
   logic [TCW-1:0]   op_addr;
   logic [7:0]       op_tile_row;
   logic             op_stall, avg_valid, avg_stall;
   tile_avg_type     avg;
   color_class_type  cls;

   // configuration registers
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // size clamping: zero acts as one, oversize saturates
   always_comb begin
      width_cmp  = CMP_W'(width_ff);
      height_cmp = CMP_W'(height_ff);
      if (width_cmp == '0) begin
         img_w = SW'(1);
      end else if (width_cmp > MAX_W_CMP) begin
         img_w = SW'(MAX_WIDTH);
      end else begin
         img_w = SW'(width_cmp);
      end
      if (height_cmp == '0) begin
         img_h = SH'(1);
      end else if (height_cmp > MAX_H_CMP) begin
         img_h = SH'(MAX_HEIGHT);
      end else begin
         img_h = SH'(height_cmp);
      end
      whole_w = img_w & ~W_LOW_MASK;
      whole_h = img_h & ~H_LOW_MASK;
   end

   // raster position of the current pixel and of the next one
   always_comb begin
      col      = req_frame_start ? '0 : col_ff;
      row      = req_frame_start ? '0 : row_ff;
      col_ext  = SW'(col);
      row_ext  = SH'(row);
      col_next = col_ext + SW'(1);
      row_next = row_ext + SH'(1);
      in_tile  = (col_ext < whole_w) && (row_ext < whole_h);

      op_ctl.first = (col[BLOCK_LOG2-1:0] == '0) && (row[BLOCK_LOG2-1:0] == '0);
      op_ctl.last  = (col[BLOCK_LOG2-1:0] == IN_TILE_LAST) &&
                     (row[BLOCK_LOG2-1:0] == IN_TILE_LAST);
      op_addr      = col[BLOCK_LOG2 +: TCW];
      op_tile_row  = 8'(row[RW-1:BLOCK_LOG2]);

      if (col_next >= img_w) begin
         col_in = '0;
         row_in = (row_next >= img_h) ? '0 : RW'(row_next);
      end else begin
         col_in = CW'(col_next);
         row_in = row;
      end
   end

   assign req_stall = op_stall;
   assign req_fire  = req_valid && !op_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // tile sum memory and averaging
   hbcc_tile_accum #(
      .BLOCK_LOG2 (BLOCK_LOG2),
      .TILE_COLS  (TILE_COLS),
      .TCW        (TCW)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (req_valid && in_tile),
      .op_stall    (op_stall),
      .op_ctl      (op_ctl),
      .op_addr     (op_addr),
      .op_tile_row (op_tile_row),
      .op_hue      (req_hue),
      .op_sat      (req_sat),
      .op_val      (req_val),
      .avg_valid   (avg_valid),
      .avg_stall   (avg_stall),
      .avg         (avg)
   );

   // classification into the result register
   assign cls       = classify(avg.hue, avg.sat, avg.val);
   assign avg_stall = rsp_valid_ff && rsp_stall;
   assign rsp_load  = avg_valid && !avg_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.tile_col <= avg.tile_col;
         rsp_ff.tile_row <= avg.tile_row;
         rsp_class_ff    <= cls;
         if (keeps_average(cls)) begin
            rsp_ff.hue <= avg.hue;
            rsp_ff.sat <= avg.sat;
            rsp_ff.val <= avg.val;
         end else begin
            rsp_ff.hue <= PLAIN_HUE;
            rsp_ff.sat <= PLAIN_SAT;
            rsp_ff.val <= PLAIN_VAL;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_col    = rsp_ff.tile_col;
   assign rsp_tile_row    = rsp_ff.tile_row;
   assign rsp_color_class = rsp_class_ff;
   assign rsp_fill_hue    = rsp_ff.hue;
   assign rsp_fill_sat    = rsp_ff.sat;
   assign rsp_fill_val    = rsp_ff.val;

endmodule

// ----- design/hbcc_tile_accum.sv -----
// hbcc_tile_accum: per tile column sum memory with read-modify-write and forwarding
// depends on hbcc_pkg (tile_ctl_type, tile_avg_type)
module hbcc_tile_accum
   import hbcc_pkg::*;
#(
   parameter int BLOCK_LOG2 = 3,
   parameter int TILE_COLS  = 256,
   parameter int TCW        = 8
) (
   input  logic           clock,
   input  logic           reset,
   // pixel request from the position logic
   input  logic           op_valid,
   output logic           op_stall,
   input  tile_ctl_type   op_ctl,
   input  logic [TCW-1:0] op_addr,
   input  logic [7:0]     op_tile_row,
   input  logic [7:0]     op_hue,
   input  logic [7:0]     op_sat,
   input  logic [7:0]     op_val,
   // finished tile averages
   output logic           avg_valid,
   input  logic           avg_stall,
   output tile_avg_type   avg
);

   localparam int SUM_W = 8 + 2 * BLOCK_LOG2;
   localparam int WORD_W = 3 * SUM_W;

   logic [WORD_W-1:0] sum_mem [TILE_COLS];

   logic              s1_valid_ff, s1_valid_in;
   tile_ctl_type      s1_ctl_ff;
   logic [TCW-1:0]    s1_addr_ff;
   logic [7:0]        s1_row_ff;
   logic [7:0]        s1_hue_ff, s1_sat_ff, s1_val_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0] fwd_data_ff;
   logic              avg_valid_ff, avg_valid_in;
   tile_avg_type      avg_ff;

   logic              op_fire, s1_fire, s1_blocked, s2_free;
   logic [WORD_W-1:0] base_word, sums_new;
   logic [SUM_W-1:0]  sum_h, sum_s, sum_v;

   // handshake between the stages
   assign s2_free    = !avg_valid_ff || !avg_stall;
   assign s1_blocked = s1_valid_ff && s1_ctl_ff.last && !s2_free;
   assign s1_fire    = s1_valid_ff && !s1_blocked;
   assign op_stall   = s1_blocked;
   assign op_fire    = op_valid && !s1_blocked;

   // new sums: a tile's first pixel starts them, others add
   always_comb begin
      base_word = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      if (s1_ctl_ff.first) begin
         sum_h = SUM_W'(s1_hue_ff);
         sum_s = SUM_W'(s1_sat_ff);
         sum_v = SUM_W'(s1_val_ff);
      end else begin
         sum_h = base_word[2*SUM_W +: SUM_W] + SUM_W'(s1_hue_ff);
         sum_s = base_word[SUM_W +: SUM_W] + SUM_W'(s1_sat_ff);
         sum_v = base_word[0 +: SUM_W] + SUM_W'(s1_val_ff);
      end
      sums_new = {sum_h, sum_s, sum_v};
   end

   // write-back that lands on the same edge as the next read is forwarded
   assign fwd_hit_in = s1_fire && (s1_addr_ff == op_addr);

   // sum memory: write back at stage 1, read at request
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         sum_mem[s1_addr_ff] <= sums_new;
      end
      if (op_fire) begin
         rd_data_ff  <= sum_mem[op_addr];
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= sums_new;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (op_fire) begin
         s1_ctl_ff  <= op_ctl;
         s1_addr_ff <= op_addr;
         s1_row_ff  <= op_tile_row;
         s1_hue_ff  <= op_hue;
         s1_sat_ff  <= op_sat;
         s1_val_ff  <= op_val;
      end
   end

   // stage valid flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (op_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      avg_valid_in = avg_valid_ff;
      if (s1_fire && s1_ctl_ff.last) begin
         avg_valid_in = 1'b1;
      end else if (!avg_stall) begin
         avg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         avg_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         avg_valid_ff <= avg_valid_in;
      end
   end

   // averages of a finished tile
   always_ff @(posedge clock) begin
      if (s1_fire && s1_ctl_ff.last) begin
         avg_ff.tile_col <= 8'(s1_addr_ff);
         avg_ff.tile_row <= s1_row_ff;
         avg_ff.hue      <= sum_h[SUM_W-1 -: 8];
         avg_ff.sat      <= sum_s[SUM_W-1 -: 8];
         avg_ff.val      <= sum_v[SUM_W-1 -: 8];
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avg       = avg_ff;

endmodule
